>>> hdl/lri_pkg.sv
package lri_pkg;

   localparam int MAX_PASSES_DEF = 80;

   localparam logic [15:0] OCT_BIAS   = 16'h8000;
   localparam logic [15:0] BOLT_BIAS  = 16'h6000;
   localparam logic [15:0] BOLT_EXTRA = 16'h13B0;
   localparam logic [7:0]  LIMIT_HI   = 8'd86;
   localparam logic [7:0]  LIMIT_ADD  = 8'd37;
   localparam logic [3:0]  START_SHIFT = 4'd6;
   localparam logic [7:0]  COLOUR_OFS = 8'd34;
   localparam logic signed [20:0] BOLT_MUL = 21'sd13;
   localparam logic signed [20:0] S16_MAX  = 21'sd32767;
   localparam logic signed [20:0] S16_MIN  = -21'sd32768;

   typedef enum logic [1:0] {
      CSR_RADIUS    = 2'd0,
      CSR_MAX_SHIFT = 2'd1,
      CSR_MAX_ITERS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic             done;
      logic [2:0][15:0] dir;
      logic [2:0][15:0] pos;
      logic [3:0]       shift;
      logic             inv;
      logic [7:0]       cnt;
      logic [7:0]       shape;
   } ray_type;

   typedef struct packed {
      ray_type          ray;
      logic [2:0][15:0] mag0;
      logic [2:0][15:0] mag1;
      logic [15:0]      limit;
   } front_type;

   typedef struct packed {
      ray_type          ray;
      logic             hit;
      logic             bolt;
      logic             ovf;
      logic [2:0][15:0] mag;
      logic [15:0]      limit;
   } test_type;

   function automatic logic [15:0] abs16(input logic [15:0] v);
      abs16 = v[15] ? 16'(16'd0 - v) : v;
   endfunction

   function automatic logic [15:0] sar16(input logic [15:0] v, input logic [3:0] s);
      sar16 = 16'($signed(v) >>> s);
   endfunction

   function automatic logic [15:0] limit_of(input logic [3:0] s);
      logic [15:0] cx;
      cx = {LIMIT_HI, 4'd0, s} >> s;
      limit_of = {8'(cx[15:8] + LIMIT_ADD), cx[7:0]};
   endfunction

endpackage

>>> hdl/lattice_raymarch_intersect.sv
// Marches one ray per clock through a fixed pipeline of MAX_PASSES passes,
// each pass three register stages (step and magnitudes, octahedron tests,
// bar and bolt test with shift update), plus one output register. A ray
// accepted with start gives its colour_index on rsp_colour_index, flagged
// by rsp_valid for one cycle, after the pass registers and the output
// register; busy is always low, so a new ray can start in every cycle.
// The receiver cannot stall: the result beat must be taken in the cycle it
// appears. Write the csr registers only when no ray is in flight.
module lattice_raymarch_intersect #(
   parameter int MAX_PASSES = lri_pkg::MAX_PASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_dir_x,
   input  logic [15:0] req_dir_y,
   input  logic [15:0] req_dir_z,
   input  logic [15:0] req_orig_x,
   input  logic [15:0] req_orig_y,
   input  logic [15:0] req_orig_z,
   output logic        rsp_valid,
   output logic [7:0]  rsp_colour_index,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);
   // configuration registers
   logic [13:0] radius_ff;
   logic [3:0]  max_shift_ff;
   logic [5:0]  max_iters_ff;
   logic [15:0] radius_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= 14'd0;
         max_shift_ff <= lri_pkg::START_SHIFT;
         max_iters_ff <= 6'd26;
      end else if (csr_we) begin
         unique case (csr_index)
            lri_pkg::CSR_RADIUS:    radius_ff    <= csr_wdata;
            lri_pkg::CSR_MAX_SHIFT: max_shift_ff <= csr_wdata[3:0];
            lri_pkg::CSR_MAX_ITERS: max_iters_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign radius_ext = {{2{radius_ff[13]}}, radius_ff};
   assign busy = 1'b0;

   // pass pipeline: ray[p] enters pass p, ray[MAX_PASSES] leaves the last
   lri_pkg::ray_type   ray   [MAX_PASSES+1];
   lri_pkg::front_type front [MAX_PASSES];
   lri_pkg::test_type  test  [MAX_PASSES];

   always_comb begin
      ray[0]       = '0;
      ray[0].valid = start;
      ray[0].dir   = {req_dir_z, req_dir_y, req_dir_x};
      ray[0].pos   = {req_orig_z, req_orig_y, req_orig_x};
      ray[0].shift = lri_pkg::START_SHIFT;
      // miss budget counts up toward zero
      ray[0].cnt   = 8'(8'd0 - {2'b0, max_iters_ff});
   end

   for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
      lri_front u_front (
         .clock   (clock),
         .reset   (reset),
         .ray_i   (ray[p]),
         .front_o (front[p])
      );
      lri_test u_test (
         .clock   (clock),
         .reset   (reset),
         .radius  (radius_ext),
         .front_i (front[p]),
         .test_o  (test[p])
      );
      lri_update u_update (
         .clock          (clock),
         .reset          (reset),
         .max_step_shift (max_shift_ff),
         .test_i         (test[p]),
         .ray_o          (ray[p+1])
      );
   end

   // colour from final count, shape code and shift
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] colour_ff, colour_in;
   lri_pkg::ray_type last;

   assign last = ray[MAX_PASSES];

   always_comb begin
      rsp_valid_in = last.valid;
      colour_in = 8'((8'(last.cnt - {4'd0, last.shift}) << 2) + last.shape
                     + {max_iters_ff, 2'b00} - lri_pkg::COLOUR_OFS);
   end

   always_ff @(posedge clock) begin
      colour_ff <= colour_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_colour_index = colour_ff;

   // a ray still marching after its passes has a nonzero budget count
   a_live_cnt: assert property (@(posedge clock) disable iff (reset)
      (last.valid && !last.done) |-> (last.cnt != 8'd0))
      else $error("live ray with exhausted count");

   // each result beat comes from a valid ray at the pipeline end
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(last.valid))
      else $error("result beat without ray");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");
endmodule

>>> hdl/lri_front.sv
module lri_front (
   input  logic               clock,
   input  logic               reset,
   input  lri_pkg::ray_type   ray_i,
   output lri_pkg::front_type front_o
);
   lri_pkg::front_type front_ff, front_in;

   always_comb begin
      front_in     = '0;
      front_in.ray = ray_i;
      if (ray_i.valid && !ray_i.done) begin
         for (int i = 0; i < 3; i++) begin
            front_in.ray.pos[i] = 16'(ray_i.pos[i]
               + (lri_pkg::sar16(ray_i.dir[i], ray_i.shift) ^ {16{ray_i.inv}}));
         end
      end
      for (int i = 0; i < 3; i++) begin
         // first octahedron is mirrored by the half-range bias
         front_in.mag0[i] = lri_pkg::abs16(16'(lri_pkg::OCT_BIAS - front_in.ray.pos[i])) >> 1;
         front_in.mag1[i] = lri_pkg::abs16(16'(16'd0 - front_in.ray.pos[i])) >> 1;
      end
      front_in.limit = lri_pkg::limit_of(ray_i.shift);
   end

   always_ff @(posedge clock) begin
      if (reset) front_ff <= '0;
      else       front_ff <= front_in;
   end

   assign front_o = front_ff;
endmodule

>>> hdl/lri_test.sv
module lri_test (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        radius,
   input  lri_pkg::front_type front_i,
   output lri_pkg::test_type  test_o
);
   lri_pkg::test_type test_ff, test_in;
   logic [15:0] acc0, acc1, accb;
   logic signed [20:0] prod;
   logic hit0, hit1, ovf;

   always_comb begin
      acc0 = 16'(radius + front_i.mag0[0] + front_i.mag0[1] + front_i.mag0[2]);
      acc1 = 16'(16'd0 - radius + front_i.mag1[0] + front_i.mag1[1] + front_i.mag1[2]);
      hit0 = acc0 < front_i.limit;
      hit1 = acc1 < front_i.limit;
      accb = 16'(acc1 - radius - radius - lri_pkg::BOLT_BIAS);
      prod = {{5{accb[15]}}, accb} * lri_pkg::BOLT_MUL;
      ovf  = (prod > lri_pkg::S16_MAX) || (prod < lri_pkg::S16_MIN);

      test_in       = '0;
      test_in.ray   = front_i.ray;
      test_in.limit = front_i.limit;
      test_in.mag   = front_i.mag1;
      test_in.ovf   = ovf;
      if (front_i.ray.valid && !front_i.ray.done) begin
         // a live ray's budget count is bumped by one in each pass
         test_in.ray.cnt = 8'(front_i.ray.cnt + 8'd1);
         if (hit0) begin
            test_in.ray.shape = 8'd0;
            test_in.hit       = 1'b1;
         end else if (hit1) begin
            test_in.ray.shape = 8'd1;
            test_in.hit       = 1'b1;
         end else begin
            test_in.bolt      = 1'b1;
            test_in.ray.shape = ovf ? 8'd2 : 8'd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) test_ff <= '0;
      else       test_ff <= test_in;
   end

   assign test_o = test_ff;
endmodule

>>> hdl/lri_update.sv
module lri_update (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        max_step_shift,
   input  lri_pkg::test_type test_i,
   output lri_pkg::ray_type  ray_o
);
   lri_pkg::ray_type ray_ff, ray_in;
   logic [15:0] extra, accc;
   logic [4:0]  nshift;
   logic [7:0]  ncnt;
   logic        hit;

   always_comb begin
      extra = test_i.ovf ? lri_pkg::BOLT_EXTRA : {16{test_i.ray.cnt[7]}};
      accc  = 16'(extra
         + lri_pkg::abs16(16'(test_i.mag[2] - test_i.mag[0]))
         + lri_pkg::abs16(16'(test_i.mag[0] - test_i.mag[1]))
         + lri_pkg::abs16(16'(test_i.mag[1] - test_i.mag[2])));
      hit    = test_i.hit || (test_i.bolt && (accc < test_i.limit));
      nshift = hit ? 5'({1'b0, test_i.ray.shift} + 5'd1)
                   : ((test_i.ray.shift == 4'd0) ? 5'd0
                                                 : 5'({1'b0, test_i.ray.shift} - 5'd1));
      ncnt   = hit ? 8'(test_i.ray.cnt - 8'd1) : test_i.ray.cnt;

      ray_in = test_i.ray;
      if (test_i.ray.valid && !test_i.ray.done) begin
         ray_in.inv   = hit;
         ray_in.shift = nshift[3:0];
         if (nshift >= {1'b0, max_step_shift}) begin
            ray_in.done = 1'b1;
         end else begin
            ray_in.cnt  = ncnt;
            ray_in.done = (ncnt == 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ray_ff <= '0;
      else       ray_ff <= ray_in;
   end

   assign ray_o = ray_ff;
endmodule
